### rtl/rpc_pkg.sv
// Package for the relation property checker: matrix size, flag width and
// the bit position of each property flag. No dependencies.
package rpc_pkg;

    localparam int MAT_DIM       = 8;
    localparam int MAT_BITS      = MAT_DIM * MAT_DIM;
    localparam int CNT_W         = 4;
    localparam int FLAG_W        = 17;
    localparam int SET_LIMIT_DEF = 8;

    // Flag positions, bit 0 upward
    localparam int FLG_ANTISYM   = 0;
    localparam int FLG_ANTITRANS = 1;
    localparam int FLG_ASYM      = 2;
    localparam int FLG_COREF     = 3;
    localparam int FLG_DENSE     = 4;
    localparam int FLG_IRREFL    = 5;
    localparam int FLG_LEUC      = 6;
    localparam int FLG_LQUASI    = 7;
    localparam int FLG_QUASI     = 8;
    localparam int FLG_REFL      = 9;
    localparam int FLG_REUC      = 10;
    localparam int FLG_RQUASI    = 11;
    localparam int FLG_SDENSE    = 12;
    localparam int FLG_SYM       = 13;
    localparam int FLG_TOTAL     = 14;
    localparam int FLG_TRANS     = 15;
    localparam int FLG_TRICH     = 16;

endpackage

### rtl/relation_property_checker_core.sv
// Relation property checker core: seventeen property flags of one 8x8 relation.
// Depends on rpc_pkg for matrix size, flag width and flag positions.
// Throughput: one item per cycle; o_busy is always low, start may be held every cycle.
// Stages: input register, parallel boolean logic over the matrix, result register.
// Reset: synchronous, active low; clears the stage valid bits only.
// Results are strobed on o_done for one cycle; the receiver cannot stall.
module relation_property_checker_core
    import rpc_pkg::*;
#(
    parameter int SET_LIMIT = SET_LIMIT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic [MAT_BITS-1:0] i_relation_bits,
    input  logic [CNT_W-1:0]    i_element_count,
    output logic                o_done,
    output logic [FLAG_W-1:0]   o_property_flags
);

    // ------------------------------------------------------------------
    // Stage 1: input register
    // ------------------------------------------------------------------
    logic                r_in_valid;
    logic [MAT_BITS-1:0] r_bits;
    logic [CNT_W-1:0]    r_count;

    // Stage 2: result register
    logic                r_out_valid;
    logic [FLAG_W-1:0]   r_flags;
    logic [FLAG_W-1:0]   n_flags;

    // No stall anywhere, so an item can enter every cycle
    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= i_start && !o_busy;
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_bits  <= i_relation_bits;
            r_count <= i_element_count;
        end
        if (r_in_valid) begin
            r_flags <= n_flags;
        end
    end

    // ------------------------------------------------------------------
    // Property logic
    // ------------------------------------------------------------------
    // Element count saturates at the set limit; full marks in-set elements.
    logic [CNT_W-1:0]   w_n;
    logic [MAT_DIM-1:0] w_full;
    logic [MAT_DIM-1:0] w_rows [MAT_DIM];
    logic [MAT_DIM-1:0] w_cols [MAT_DIM];
    logic [MAT_DIM-1:0] w_diag;

    assign w_n = (r_count > CNT_W'(SET_LIMIT)) ? CNT_W'(SET_LIMIT) : r_count;

    always_comb begin
        for (int k = 0; k < MAT_DIM; k++) begin
            w_full[k] = (CNT_W'(k) < w_n);
        end
    end

    // Masked rows and their transpose. Out-of-set rows and columns are zero.
    always_comb begin
        for (int i = 0; i < MAT_DIM; i++) begin
            for (int j = 0; j < MAT_DIM; j++) begin
                w_rows[i][j] = r_bits[MAT_DIM*i + j] & w_full[i] & w_full[j];
                w_cols[j][i] = r_bits[MAT_DIM*i + j] & w_full[i] & w_full[j];
            end
            w_diag[i] = r_bits[MAT_DIM*i + i] & w_full[i];
        end
    end

    // Per-row violation bits. A zero row passes every row test, so only
    // total and trichotomy need gating by set membership.
    logic [MAT_DIM-1:0] w_bad_antisym, w_bad_asym, w_bad_coref, w_bad_lquasi;
    logic [MAT_DIM-1:0] w_bad_rquasi, w_bad_sym, w_bad_total, w_bad_trich;

    always_comb begin
        for (int i = 0; i < MAT_DIM; i++) begin
            logic [MAT_DIM-1:0] self;
            logic [MAT_DIM-1:0] off;
            self = '0;
            self[i] = 1'b1;
            off  = w_rows[i] & ~self;
            w_bad_antisym[i] = |(w_rows[i] & w_cols[i] & ~self);
            w_bad_asym[i]    = |(w_rows[i] & w_cols[i]);
            w_bad_coref[i]   = |off;
            w_bad_lquasi[i]  = (|off) && !w_diag[i];
            w_bad_rquasi[i]  = |(off & ~w_diag);
            w_bad_sym[i]     = (w_rows[i] != w_cols[i]);
            w_bad_total[i]   = w_full[i] && ((w_rows[i] | w_cols[i]) != w_full);
            w_bad_trich[i]   = w_full[i] && ((w_rows[i] ^ w_cols[i]) != (w_full & ~self));
        end
    end

    // Per-pair violation bits, index MAT_DIM*i+j, all pairs independent.
    logic [MAT_BITS-1:0] w_bad_dense, w_bad_sdense, w_bad_reuc;
    logic [MAT_BITS-1:0] w_bad_trans, w_bad_antitrans, w_bad_leuc;

    always_comb begin
        for (int i = 0; i < MAT_DIM; i++) begin
            for (int j = 0; j < MAT_DIM; j++) begin
                logic [MAT_DIM-1:0] excl;
                logic               rel;
                excl    = '1;
                excl[i] = 1'b0;
                excl[j] = 1'b0;
                rel     = w_rows[i][j];
                // Dense: some z between i and j
                w_bad_dense[MAT_DIM*i + j]  = rel && !(|(w_rows[i] & w_cols[j]));
                // Strictly dense: z distinct from both ends, distinct pairs only
                w_bad_sdense[MAT_DIM*i + j] = rel && (i != j) &&
                                              !(|(w_rows[i] & w_cols[j] & excl));
                w_bad_reuc[MAT_DIM*i + j]   = rel && (|(w_rows[i] & ~w_rows[j]));
                w_bad_trans[MAT_DIM*i + j]  = rel && (|(w_rows[j] & ~w_rows[i]));
                w_bad_antitrans[MAT_DIM*i + j] = rel && (|(w_rows[i] & w_rows[j]));
                // Left euclidean works on j related to i
                w_bad_leuc[MAT_DIM*i + j]   = w_cols[i][j] && (|(w_cols[i] & ~w_rows[j]));
            end
        end
    end

    always_comb begin
        n_flags                = '0;
        n_flags[FLG_ANTISYM]   = ~|w_bad_antisym;
        n_flags[FLG_ANTITRANS] = ~|w_bad_antitrans;
        n_flags[FLG_ASYM]      = ~|w_bad_asym;
        n_flags[FLG_COREF]     = ~|w_bad_coref;
        n_flags[FLG_DENSE]     = ~|w_bad_dense;
        n_flags[FLG_IRREFL]    = ~|w_diag;
        n_flags[FLG_LEUC]      = ~|w_bad_leuc;
        n_flags[FLG_LQUASI]    = ~|w_bad_lquasi;
        n_flags[FLG_QUASI]     = (~|w_bad_lquasi) && (~|w_bad_rquasi);
        n_flags[FLG_REFL]      = (w_diag == w_full);
        n_flags[FLG_REUC]      = ~|w_bad_reuc;
        n_flags[FLG_RQUASI]    = ~|w_bad_rquasi;
        n_flags[FLG_SDENSE]    = ~|w_bad_sdense;
        n_flags[FLG_SYM]       = ~|w_bad_sym;
        n_flags[FLG_TOTAL]     = ~|w_bad_total;
        n_flags[FLG_TRANS]     = ~|w_bad_trans;
        // Trichotomy also needs an empty diagonal
        n_flags[FLG_TRICH]     = (~|w_bad_trich) && (~|w_diag);
    end

    assign o_done           = r_out_valid;
    assign o_property_flags = r_flags;

`ifndef SYNTHESIS
    // Every accepted item comes out on o_done after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##2 o_done)
        else $error("accepted item did not produce a result");

    // Empty set satisfies every property
    a_empty_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && (r_count == '0)) |=> (o_property_flags == {FLAG_W{1'b1}}))
        else $error("empty set did not give all flags");

    // A total relation is reflexive
    a_total_refl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_property_flags[FLG_TOTAL]) |-> o_property_flags[FLG_REFL])
        else $error("total without reflexive");

    // Asymmetric implies antisymmetric and irreflexive
    a_asym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_property_flags[FLG_ASYM]) |->
        (o_property_flags[FLG_ANTISYM] && o_property_flags[FLG_IRREFL]))
        else $error("asymmetric without antisymmetric and irreflexive");
`endif

endmodule

### sim/relation_property_checker_core_tb.sv
// Testbench for relation_property_checker_core: directed and random relations,
// each checked against a local model of the seventeen property flags.
// Depends on rpc_pkg and the core RTL only.
module relation_property_checker_core_tb;
    import rpc_pkg::*;

    typedef enum int {
        REL_NOISE, REL_SPARSE, REL_DENSE, REL_SYMMETRIC, REL_EQUIV,
        REL_ORDER, REL_STRICT_ORDER, REL_CLOSURE, REL_DIAG
    } t_rel_kind;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_start = 1'b0;
    logic [MAT_BITS-1:0] i_relation_bits = '0;
    logic [CNT_W-1:0]    i_element_count = '0;
    logic                o_busy;
    logic                o_done;
    logic [FLAG_W-1:0]   o_property_flags;

    logic [FLAG_W-1:0] pending_flags[$];
    int                error_count = 0;
    bit                quiet = 1'b0;    // no idle cycles between items while set

    relation_property_checker_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .o_busy           (o_busy),
        .i_relation_bits  (i_relation_bits),
        .i_element_count  (i_element_count),
        .o_done           (o_done),
        .o_property_flags (o_property_flags)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Expected flags for one relation; out-of-set rows and columns are masked.
    function automatic logic [FLAG_W-1:0] predict_properties(
        input logic [MAT_BITS-1:0] bits, input logic [CNT_W-1:0] cnt);
        int n, i, j;
        bit [7:0] rows[8], cols[8];
        bit [7:0] full, diag, self_b, jb, off;
        bit antisym, antitrans, asym, coref, dense, leuc, lquasi;
        bit reuc, rquasi, sdense, sym, total, trans, trich;
        logic [FLAG_W-1:0] f;
        n = (cnt > SET_LIMIT_DEF) ? SET_LIMIT_DEF : int'(cnt);
        full = 8'((9'd1 << n) - 9'd1);
        diag = '0;
        {antisym, antitrans, asym, coref, dense, leuc, lquasi} = '1;
        {reuc, rquasi, sdense, sym, total, trans, trich} = '1;
        for (i = 0; i < 8; i++) begin
            rows[i] = (i < n) ? (bits[8*i +: 8] & full) : 8'h00;
            cols[i] = '0;
        end
        for (i = 0; i < n; i++) begin
            for (j = 0; j < n; j++)
                if (rows[i][j]) cols[j][i] = 1'b1;
            if (rows[i][i]) diag[i] = 1'b1;
        end
        for (i = 0; i < n; i++) begin
            self_b = 8'h01 << i;
            off = rows[i] & ~self_b;
            if ((rows[i] & cols[i] & ~self_b) != 0) antisym = 0;
            if ((rows[i] & cols[i]) != 0) asym = 0;
            if (off != 0) coref = 0;
            if (off != 0 && (diag & self_b) == 0) lquasi = 0;
            if ((off & ~diag) != 0) rquasi = 0;
            if (rows[i] != cols[i]) sym = 0;
            if ((rows[i] | cols[i]) != full) total = 0;
            if ((rows[i] ^ cols[i]) != (full & ~self_b)) trich = 0;
            for (j = 0; j < n; j++) begin
                jb = 8'h01 << j;
                if ((rows[i] & jb) != 0) begin
                    if ((rows[i] & cols[j]) == 0) dense = 0;
                    if (j != i && (rows[i] & cols[j] & ~self_b & ~jb) == 0) sdense = 0;
                    if ((rows[i] & ~rows[j]) != 0) reuc = 0;
                    if ((rows[j] & ~rows[i]) != 0) trans = 0;
                    if ((rows[i] & rows[j]) != 0) antitrans = 0;
                end
                if ((cols[i] & jb) != 0 && (cols[i] & ~rows[j]) != 0) leuc = 0;
            end
        end
        if (diag != 0) trich = 0;
        f = '0;
        f[FLG_ANTISYM]   = antisym;
        f[FLG_ANTITRANS] = antitrans;
        f[FLG_ASYM]      = asym;
        f[FLG_COREF]     = coref;
        f[FLG_DENSE]     = dense;
        f[FLG_IRREFL]    = (diag == 0);
        f[FLG_LEUC]      = leuc;
        f[FLG_LQUASI]    = lquasi;
        f[FLG_QUASI]     = lquasi && rquasi;
        f[FLG_REFL]      = (diag == full);
        f[FLG_REUC]      = reuc;
        f[FLG_RQUASI]    = rquasi;
        f[FLG_SDENSE]    = sdense;
        f[FLG_SYM]       = sym;
        f[FLG_TOTAL]     = total;
        f[FLG_TRANS]     = trans;
        f[FLG_TRICH]     = trich;
        return f;
    endfunction

    // Structured relation of the given kind on n elements, with an occasional
    // flipped bit and random junk outside the set.
    function automatic logic [MAT_BITS-1:0] random_relation(input t_rel_kind kind,
                                                            input int n);
        bit [7:0] m[8];
        int perm[8];
        int cls[8];
        int i, j, k, t;
        bit [7:0] in_mask;
        logic [MAT_BITS-1:0] r;
        in_mask = 8'((9'd1 << n) - 9'd1);
        for (i = 0; i < 8; i++) begin
            m[i] = '0;
            perm[i] = i;
            cls[i] = $urandom_range(0, 2);
        end
        for (i = 7; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        for (i = 0; i < 8; i++) begin
            for (j = 0; j < 8; j++) begin
                case (kind)
                    REL_NOISE:        m[i][j] = 1'($urandom_range(0, 1));
                    REL_SPARSE:       m[i][j] = ($urandom_range(0, 7) == 0);
                    REL_DENSE:        m[i][j] = ($urandom_range(0, 7) != 0);
                    REL_SYMMETRIC: begin
                        if ($urandom_range(0, 3) == 0) begin
                            m[i][j] = 1'b1;
                            m[j][i] = 1'b1;
                        end
                    end
                    REL_EQUIV:        m[i][j] = (cls[i] == cls[j]);
                    REL_ORDER:        m[i][j] = (perm[i] <= perm[j]);
                    REL_STRICT_ORDER: m[i][j] = (perm[i] < perm[j]);
                    REL_CLOSURE:      m[i][j] = ($urandom_range(0, 4) == 0);
                    REL_DIAG:         m[i][j] = (i == j) && $urandom_range(0, 1);
                    default:          m[i][j] = 1'b0;
                endcase
            end
        end
        if (kind == REL_CLOSURE) begin
            for (k = 0; k < 8; k++)
                for (i = 0; i < 8; i++)
                    if (m[i][k]) m[i] |= m[k];
        end
        // broken variant
        if ($urandom_range(0, 3) == 0)
            m[3'($urandom_range(0, 7))][3'($urandom_range(0, 7))] ^= 1'b1;
        for (i = 0; i < 8; i++) begin
            m[i] = (i < n) ? (m[i] & in_mask) : 8'h00;
            if ($urandom_range(0, 1))
                m[i] |= (i < n) ? (8'($urandom) & ~in_mask) : 8'($urandom);
            r[8*i +: 8] = m[i];
        end
        return r;
    endfunction

    // Result check and expectation push share one process; both read the
    // values that were present before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_flags.size() == 0) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("%0t: unexpected result flags=%05h", $time,
                                 o_property_flags);
                end else begin
                    if (o_property_flags !== pending_flags[0]) begin
                        error_count++;
                        if (error_count <= 10)
                            $display("%0t: property_flags expected %05h got %05h",
                                     $time, pending_flags[0], o_property_flags);
                    end
                    void'(pending_flags.pop_front());
                end
            end
            if (i_start && !o_busy)
                pending_flags.push_back(predict_properties(i_relation_bits,
                                                           i_element_count));
        end
    end

    // Present one item after a random gap (none while quiet is set) and return at the accepting edge.
    task automatic send_item(input logic [MAT_BITS-1:0] bits,
                             input logic [CNT_W-1:0] cnt);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start         <= 1'b1;
        i_relation_bits <= bits;
        i_element_count <= cnt;
        do @(posedge i_clk); while (o_busy);
    endtask

    // Stop sending and wait until every expected result has come back.
    task automatic drain_results();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending_flags.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_empty_set();
        send_item('1, 4'd0);
        send_item('0, 4'd0);
        send_item(64'hDEAD_BEEF_0123_4567, 4'd0);
    endtask

    task automatic test_extremes();
        send_item('0, 4'd8);
        send_item('1, 4'd8);
        send_item(64'hAAAA_AAAA_AAAA_AAAA, 4'd8);
        send_item(64'h5555_5555_5555_5555, 4'd8);
        send_item(64'h0000_0000_0000_0001, 4'd1);
        send_item(64'hFFFF_FFFF_FFFF_FFFE, 4'd1);
    endtask

    // Counts above the set limit behave as the limit
    task automatic test_oversized_count();
        send_item('1, 4'd15);
        send_item(64'h8040_2010_0804_0201, 4'd9);
        send_item(64'h0080_C0E0_F0F8_FCFE, 4'd12);
    endtask

    task automatic test_classic_relations();
        send_item(64'h8040_2010_0804_0201, 4'd8);   // identity
        send_item(64'h0080_C0E0_F0F8_FCFE, 4'd8);   // strict order, trichotomous
        send_item(64'h80C0_E0F0_F8FC_FEFF, 4'd8);   // total order
        send_item(64'h7FBF_DFEF_F7FB_FDFE, 4'd8);   // complete minus diagonal
        send_item(64'h0000_0000_0001_0402, 4'd3);   // rotation 0->1->2->0
        send_item(64'hFFFF_FFFF_F8F4_F2F1, 4'd4);   // identity plus out-of-set junk
        send_item(64'h0000_0000_0000_0003, 4'd2);   // left but not right quasi-reflexive
        send_item(64'h0000_0000_0000_0202, 4'd2);   // right but not left
    endtask

    // Density needs a middle element; strict density needs one distinct from both ends
    task automatic test_density();
        send_item(64'h0000_0000_0000_0002, 4'd2);
        send_item(64'h0000_0000_0000_0203, 4'd2);
        send_item(64'h0000_0000_0002_0006, 4'd3);
        send_item(64'h0000_0000_0007_0707, 4'd3);
    endtask

    task automatic test_random(input int num);
        int k, n;
        logic [CNT_W-1:0] cnt;
        t_rel_kind kind;
        for (k = 0; k < num; k++) begin
            if (k % 40 == 0) quiet = ($urandom_range(0, 2) == 0);
            if ($urandom_range(0, 9) == 0) cnt = CNT_W'($urandom_range(0, 15));
            else cnt = CNT_W'($urandom_range(1, 8));
            n = (cnt > SET_LIMIT_DEF) ? SET_LIMIT_DEF : int'(cnt);
            kind = t_rel_kind'($urandom_range(0, int'(REL_DIAG)));
            send_item(random_relation(kind, n), cnt);
        end
        quiet = 1'b0;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_empty_set();
        test_extremes();
        test_oversized_count();
        test_classic_relations();
        test_density();
        test_random(460);
        drain_results();    // sender holds off until the pipeline is empty
        test_random(470);
        drain_results();
        if (error_count == 0 && pending_flags.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/rpc_pkg.sv
rtl/relation_property_checker_core.sv
sim/relation_property_checker_core_tb.sv
